>>> sv/tscb_pkg.sv
// Shared types and constants for the thermistor summary CAN broadcaster.
// Used by the top level, the divider and the port checker; depends on nothing.
package tscb_pkg;

	typedef struct packed {
		logic              action;
		logic [6:0]        sample_index;
		logic signed [7:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  byte4;
		logic [7:0]  byte5;
		logic [7:0]  byte6;
		logic [7:0]  byte7;
		logic        last_frame;
	} out_item_t;

	// Accumulator widths cover up to 80 readings of -34..127.
	localparam int SUM_W = 15;
	localparam int MAG_W = 14;
	localparam int CNT_W = 7;

	localparam logic [28:0]       SUMMARY_ID      = 29'h1839F380;
	localparam logic [28:0]       DETAIL_ID       = 29'h1838F380;
	localparam logic [7:0]        CHECK_SEED      = 8'h41;
	localparam logic [6:0]        MODULE_STRIDE   = 7'd80;
	localparam logic signed [7:0] VALID_FLOOR     = -8'sd35;
	localparam logic [6:0]        EXCLUDED_ENTRY  = 7'd25;
	localparam logic [2:0]        EXCLUDED_MODULE = 3'd1;
	localparam logic signed [7:0] MIN_INIT        = 8'sd127;
	localparam logic signed [7:0] MAX_INIT        = -8'sd128;

	// Register index, taken from paddr[2].
	localparam logic REG_MODULE_NUMBER = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_DETAIL
	} state_t;

	typedef struct packed {
		logic             go;
		logic [MAG_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> sv/thermistor_summary_can_broadcaster.sv
// Top level of the thermistor summary CAN broadcaster.
// Depends on tscb_pkg and instantiates tscb_div.
//
// A load transaction (action 0) writes one store entry when its index is in range and leaves
// the block idle; busy never rises for it. A tick transaction (action 1) reads the store one
// entry per cycle through its single read port, then runs the divider for the average while
// busy stays high. The summary frame strobes in the cycle before the detail frame; each
// strobe lasts one cycle and cannot be held off, and a new transaction may start in the
// cycle that shows the detail frame.
module thermistor_summary_can_broadcaster #(
	parameter int SENSOR_COUNT = 80
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  tscb_pkg::in_item_t   cmd,
	output logic                 strobe,
	output tscb_pkg::out_item_t  result
);
	import tscb_pkg::*;

	localparam int AW = $clog2(SENSOR_COUNT);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(SENSOR_COUNT - 1);
	localparam logic [6:0]    DEPTH7     = 7'(SENSOR_COUNT);
	localparam logic [7:0]    COUNT_BYTE = 8'(SENSOR_COUNT);
	localparam logic [7:0]    LAST_BYTE  = 8'(SENSOR_COUNT - 1);

	state_t            state_q, nxt_state;
	logic [2:0]        mod_q;
	logic [6:0]        rot_q;
	logic [6:0]        idx_eff;
	logic [AW-1:0]     scan_q;

	logic [7:0]              mem [SENSOR_COUNT];
	logic [SENSOR_COUNT-1:0] vld_q;
	logic [7:0]              rd_mem_s1;
	logic                    rd_ok_s1;
	logic                    rd_go_s1;
	logic [AW-1:0]           rd_idx_s1;
	logic signed [7:0]       rd_val;

	logic signed [7:0]       min_q, max_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [7:0]              det_val_q;
	logic                    take;

	logic              load_we, tick_acc, cfg_we;
	logic              emit_sum, emit_det;
	logic              div_go;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic [SUM_W-1:0]  sum_mag;
	logic [7:0]        q8, avg_b, check;
	logic [9:0]        absid;
	out_item_t         sum_frame, det_frame;
	logic              strobe_q;
	out_item_t         result_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MODULE_NUMBER);
	assign prdata = (paddr[2] == REG_MODULE_NUMBER) ? {29'b0, mod_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= '0;
		else if (cfg_we)
			mod_q <= pwdata[2:0];
	end

	assign busy     = (state_q != ST_IDLE);
	assign tick_acc = start && !busy && cmd.action;
	assign load_we  = start && !busy && !cmd.action && (cmd.sample_index < DEPTH7);

	// Sample store; an entry never written reads as zero through its valid bit.
	always_ff @(posedge clk) begin
		if (load_we)
			mem[cmd.sample_index[AW-1:0]] <= cmd.sample_value;
		rd_mem_s1 <= mem[scan_q];
		rd_ok_s1  <= vld_q[scan_q];
		rd_idx_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (load_we)
			vld_q[cmd.sample_index[AW-1:0]] <= 1'b1;
	end

	// Scan address counter and read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			rd_go_s1 <= 1'b0;
		end else begin
			rd_go_s1 <= (state_q == ST_SCAN);
			if (tick_acc)
				scan_q <= '0;
			else if (state_q == ST_SCAN && scan_q != LAST_ADDR)
				scan_q <= scan_q + 1'b1;
		end
	end

	assign idx_eff = (rot_q >= DEPTH7) ? 7'd0 : rot_q;
	assign rd_val  = rd_ok_s1 ? signed'(rd_mem_s1) : 8'sd0;
	assign take    = (rd_val > VALID_FLOOR)
		&& !(mod_q == EXCLUDED_MODULE && 7'(rd_idx_s1) == EXCLUDED_ENTRY);

	// Running minimum, maximum, sum and count
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			min_q <= MIN_INIT;
			max_q <= MAX_INIT;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (rd_go_s1) begin
			if (take) begin
				if (rd_val < min_q)
					min_q <= rd_val;
				if (rd_val > max_q)
					max_q <= rd_val;
				sum_q <= sum_q + SUM_W'(rd_val);
				cnt_q <= cnt_q + 1'b1;
			end
			if (7'(rd_idx_s1) == idx_eff)
				det_val_q <= rd_val;
		end
	end

	// Divide the magnitude of the sum, then restore the sign.
	assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign div_req = {div_go, sum_mag[MAG_W-1:0], (cnt_q == '0) ? CNT_W'(1) : cnt_q};

	tscb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign q8    = div_rsp.quotient[7:0];
	assign avg_b = sum_q[SUM_W-1] ? (~q8 + 8'd1) : q8;
	assign check = CHECK_SEED + {5'b0, mod_q} + min_q + max_q + avg_b + COUNT_BYTE + LAST_BYTE;
	assign absid = 10'(mod_q) * 10'(MODULE_STRIDE) + 10'(idx_eff);

	always_comb begin
		sum_frame.frame_id   = SUMMARY_ID;
		sum_frame.byte0      = {5'b0, mod_q};
		sum_frame.byte1      = min_q;
		sum_frame.byte2      = max_q;
		sum_frame.byte3      = avg_b;
		sum_frame.byte4      = COUNT_BYTE;
		sum_frame.byte5      = LAST_BYTE;
		sum_frame.byte6      = 8'd0;
		sum_frame.byte7      = check;
		sum_frame.last_frame = 1'b0;

		det_frame.frame_id   = DETAIL_ID;
		det_frame.byte0      = {6'b0, absid[9:8]};
		det_frame.byte1      = absid[7:0];
		det_frame.byte2      = det_val_q;
		det_frame.byte3      = {1'b0, idx_eff};
		det_frame.byte4      = min_q;
		det_frame.byte5      = max_q;
		det_frame.byte6      = LAST_BYTE;
		det_frame.byte7      = 8'd0;
		det_frame.last_frame = 1'b1;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= nxt_state;
	end

	always_comb begin
		nxt_state = state_q;
		div_go    = 1'b0;
		emit_sum  = 1'b0;
		emit_det  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (tick_acc)
					nxt_state = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_q == LAST_ADDR)
					nxt_state = ST_DRAIN;
			end
			ST_DRAIN: nxt_state = ST_DIVGO;
			ST_DIVGO: begin
				div_go    = 1'b1;
				nxt_state = ST_DIVWAIT;
			end
			ST_DIVWAIT: begin
				if (div_rsp.done) begin
					emit_sum  = 1'b1;
					nxt_state = ST_DETAIL;
				end
			end
			ST_DETAIL: begin
				emit_det  = 1'b1;
				nxt_state = ST_IDLE;
			end
			default: nxt_state = ST_IDLE;
		endcase
	end

	// Rotating detail index and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_sum || emit_det;
			if (emit_det)
				rot_q <= (idx_eff + 7'd1 >= DEPTH7) ? 7'd0 : idx_eff + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_sum)
			result_q <= sum_frame;
		else if (emit_det)
			result_q <= det_frame;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> sv/tscb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tscb_pkg for the request and response structs.
module tscb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tscb_pkg::div_req_t  req,
	output tscb_pkg::div_rsp_t  rsp
);
	import tscb_pkg::*;

	localparam int STEP_W = $clog2(MAG_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

	logic [MAG_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W:0]    diff;

	always_comb begin
		trial = {rem_q, quo_q[MAG_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == LAST_STEP);
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> sv/tscb_checker.sv
// Port-level checker for the thermistor summary CAN broadcaster and its bind.
// Depends on tscb_pkg; sees only the top level's ports.
module tscb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input tscb_pkg::in_item_t   cmd,
	input logic                 strobe,
	input tscb_pkg::out_item_t  result
);
	import tscb_pkg::*;

	// A summary frame is always followed at once by its detail frame.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_frame |=> strobe && result.last_frame)
		else $error("summary frame not followed by detail frame");

	// Nothing is emitted right after the detail frame.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_frame |=> !strobe)
		else $error("frame emitted after detail frame");

	// The summary frame appears while the tick transaction is still in progress.
	a_sum_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_frame |-> busy)
		else $error("summary frame while idle");

	// A tick transaction makes the block busy.
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action |=> busy && !strobe)
		else $error("tick transaction did not start a scan");

	// A load transaction produces no frame and leaves the block idle.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cmd.action |=> !busy && !strobe)
		else $error("load transaction disturbed the block");

endmodule

bind thermistor_summary_can_broadcaster tscb_checker u_tscb_checker (.*);

>>> test/tscb_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker for the thermistor summary CAN broadcaster: mirrors the sample store,
// predicts the summary and detail frames of every tick and compares each strobed frame.
// Depends on tscb_pkg; instantiated next to the block by the testbench top.
module tscb_frame_checker #(
	parameter int SENSOR_COUNT = 80
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	input  logic                 start,
	input  logic                 busy,
	input  tscb_pkg::in_item_t   cmd,
	input  logic                 strobe,
	input  tscb_pkg::out_item_t  result,
	output int                   mismatches,
	output int                   outstanding
);
	import tscb_pkg::*;

	localparam logic ACT_TICK = 1'b1;
	localparam int   NUM_FIELDS = 10;

	logic signed [7:0] temps [SENSOR_COUNT];
	logic [6:0]        detail_idx;
	logic [2:0]        module_num;
	out_item_t         expected_frames [$];

	initial mismatches = 0;

	function automatic logic [28:0] field_at(input out_item_t f, input int k);
		case (k)
			0: field_at = f.frame_id;
			1: field_at = 29'(f.byte0);
			2: field_at = 29'(f.byte1);
			3: field_at = 29'(f.byte2);
			4: field_at = 29'(f.byte3);
			5: field_at = 29'(f.byte4);
			6: field_at = 29'(f.byte5);
			7: field_at = 29'(f.byte6);
			8: field_at = 29'(f.byte7);
			default: field_at = 29'(f.last_frame);
		endcase
	endfunction

	function automatic string field_name(input int k);
		case (k)
			0: field_name = "frame_id";
			1: field_name = "byte0";
			2: field_name = "byte1";
			3: field_name = "byte2";
			4: field_name = "byte3";
			5: field_name = "byte4";
			6: field_name = "byte5";
			7: field_name = "byte6";
			8: field_name = "byte7";
			default: field_name = "last_frame";
		endcase
	endfunction

	// A tick scans the store, then queues the summary frame and the detail frame.
	task automatic predict_frames();
		int         i;
		int         lo, hi, total, valid, mean;
		logic [6:0] idx;
		logic [15:0] abs_id;
		out_item_t  sum_f, det_f;
		lo = MIN_INIT;
		hi = MAX_INIT;
		total = 0;
		valid = 0;
		for (i = 0; i < SENSOR_COUNT; i++) begin
			if (temps[i] > VALID_FLOOR &&
					!(module_num == EXCLUDED_MODULE && i == EXCLUDED_ENTRY)) begin
				valid++;
				total += temps[i];
				if (temps[i] < lo) lo = temps[i];
				if (temps[i] > hi) hi = temps[i];
			end
		end
		// With no usable reading the divisor is forced to one.
		if (valid == 0) valid = 1;
		mean = total / valid;

		sum_f.frame_id   = SUMMARY_ID;
		sum_f.byte0      = {5'b0, module_num};
		sum_f.byte1      = lo[7:0];
		sum_f.byte2      = hi[7:0];
		sum_f.byte3      = mean[7:0];
		sum_f.byte4      = 8'(SENSOR_COUNT);
		sum_f.byte5      = 8'(SENSOR_COUNT - 1);
		sum_f.byte6      = 8'd0;
		sum_f.byte7      = CHECK_SEED + sum_f.byte0 + sum_f.byte1 + sum_f.byte2 + sum_f.byte3
			+ sum_f.byte4 + sum_f.byte5 + sum_f.byte6;
		sum_f.last_frame = 1'b0;

		idx = (detail_idx >= SENSOR_COUNT) ? 7'd0 : detail_idx;
		abs_id = 16'(module_num) * 16'(MODULE_STRIDE) + 16'(idx);
		det_f.frame_id   = DETAIL_ID;
		det_f.byte0      = abs_id[15:8];
		det_f.byte1      = abs_id[7:0];
		det_f.byte2      = temps[idx];
		det_f.byte3      = {1'b0, idx};
		det_f.byte4      = lo[7:0];
		det_f.byte5      = hi[7:0];
		det_f.byte6      = 8'(SENSOR_COUNT - 1);
		det_f.byte7      = 8'd0;
		det_f.last_frame = 1'b1;

		expected_frames.push_back(sum_f);
		expected_frames.push_back(det_f);
		detail_idx = (int'(idx) + 1 >= SENSOR_COUNT) ? 7'd0 : idx + 7'd1;
	endtask

	task automatic check_frame(input out_item_t got);
		out_item_t want;
		int        k;
		if (expected_frames.size() == 0) begin
			$error("frame with id %h arrived with none expected", got.frame_id);
			mismatches++;
		end else begin
			want = expected_frames.pop_front();
			for (k = 0; k < NUM_FIELDS; k++) begin
				if (field_at(want, k) !== field_at(got, k)) begin
					$error("%s: expected %h, actual %h", field_name(k),
						field_at(want, k), field_at(got, k));
					mismatches++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (temps[i]) temps[i] = '0;
			detail_idx = '0;
			module_num = '0;
			expected_frames.delete();
			outstanding <= 0;
		end else begin
			if (strobe) check_frame(result);
			if (psel && penable && pwrite && pready && paddr[2] == REG_MODULE_NUMBER)
				module_num = pwdata[2:0];
			if (start && !busy) begin
				if (cmd.action == ACT_TICK)
					predict_frames();
				else if (cmd.sample_index < SENSOR_COUNT)
					temps[cmd.sample_index] = cmd.sample_value;
			end
			outstanding <= expected_frames.size();
		end
	end

endmodule

>>> test/tb_thermistor_summary_can_broadcaster.sv
`timescale 1ns / 100ps
// Testbench top for the thermistor summary CAN broadcaster: drives load and tick
// transactions in bursts, sets the module number over APB and gives the verdict.
// Depends on tscb_pkg, the block and tscb_frame_checker.
module tb_thermistor_summary_can_broadcaster;
	import tscb_pkg::*;

	localparam int   SENSOR_COUNT = 80;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam int   NUM_PHASES = 6;
	localparam int   PHASE_ITEMS = 92;
	localparam int   DRAIN_CYCLES = 110;
	localparam int   STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		FILL_COLD,
		FILL_HOT
	} fill_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    cmd = '0;
	logic        strobe;
	out_item_t   result;
	int          mismatches;
	int          outstanding;
	int          burst_left = 1;
	int          idle_cycles = 0;

	thermistor_summary_can_broadcaster #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	tscb_frame_checker #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Ends the run when nothing has moved on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Upper bits of pwdata are random; only the low three bits form the module number.
	task automatic reg_write(input logic [2:0] mod);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MODULE_NUMBER, 2'b00};
		pwdata <= {29'($urandom()), mod};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every predicted frame has been seen and the block has gone quiet.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic send(input logic action, input logic [6:0] idx,
			input logic signed [7:0] value);
		in_item_t item;
		int       gap;
		item.action = action;
		item.sample_index = idx;
		item.sample_value = value;
		start <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (busy);
		burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 15);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Values cluster at the validity floor and at both ends of the range.
	function automatic logic signed [7:0] pick_temp();
		int r;
		r = $urandom_range(0, 15);
		if (r < 4) pick_temp = -8'sd36 + 8'($urandom_range(0, 2));
		else if (r == 4) pick_temp = 8'sd127;
		else if (r == 5) pick_temp = -8'sd128;
		else pick_temp = 8'($urandom());
	endfunction

	function automatic logic [6:0] pick_index();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) pick_index = EXCLUDED_ENTRY;
		else if (r == 1) pick_index = 7'($urandom_range(SENSOR_COUNT, 127));
		else if (r == 2) pick_index = 7'(SENSOR_COUNT - 1);
		else pick_index = 7'($urandom_range(0, SENSOR_COUNT - 1));
	endfunction

	task automatic send_random();
		if ($urandom_range(0, 4) < 2)
			send(ACT_TICK, 7'($urandom()), 8'($urandom()));
		else
			send(ACT_LOAD, pick_index(), pick_temp());
	endtask

	// Rewrites the whole store, then ticks. A cold fill leaves only the excluded
	// entry above the floor, so with module 1 no reading is usable at all.
	task automatic sweep(input fill_t kind);
		int i;
		int v;
		for (i = 0; i < SENSOR_COUNT; i++) begin
			if (kind == FILL_HOT)
				v = 127;
			else if (i == EXCLUDED_ENTRY)
				v = $urandom_range(0, 127);
			else
				v = -int'($urandom_range(35, 128));
			send(ACT_LOAD, 7'(i), v[7:0]);
		end
		send(ACT_TICK, 7'($urandom()), 8'($urandom()));
	endtask

	initial begin
		int p;
		int m;
		int left;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACT_TICK, 7'd0, 8'sd0);
		send(ACT_LOAD, 7'd0, 8'sd127);
		send(ACT_LOAD, 7'(SENSOR_COUNT - 1), -8'sd128);
		send(ACT_LOAD, 7'd1, -8'sd35);
		send(ACT_LOAD, 7'd2, -8'sd34);
		send(ACT_LOAD, 7'(SENSOR_COUNT), 8'sd55);
		send(ACT_LOAD, 7'd127, -8'sd1);
		send(ACT_TICK, 7'd127, -8'sd1);
		send(ACT_LOAD, EXCLUDED_ENTRY, 8'sd100);
		send(ACT_TICK, 7'd0, 8'sd0);
		settle();
		reg_write(EXCLUDED_MODULE);
		send(ACT_TICK, 7'd0, 8'sd0);
		send(ACT_LOAD, EXCLUDED_ENTRY, -8'sd128);
		send(ACT_TICK, 7'd0, 8'sd0);
		settle();
		reg_write(3'd7);
		// A small negative sum over many readings must truncate to zero, not -1.
		send(ACT_LOAD, 7'd0, -8'sd30);
		send(ACT_TICK, 7'd0, 8'sd0);

		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: m = EXCLUDED_MODULE;
				1: m = 0;
				2: m = 7;
				default: m = $urandom_range(0, 7);
			endcase
			reg_write(m[2:0]);
			left = PHASE_ITEMS;
			if (p == 0) begin
				sweep(FILL_COLD);
				left -= SENSOR_COUNT + 1;
			end else if (p == 2) begin
				sweep(FILL_HOT);
				left -= SENSOR_COUNT + 1;
			end
			repeat (left) send_random();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
